// ===== hdl/range_reserve_add_assign_min_unit_assert.svh =====
// ============================================================================
// range_reserve_add_assign_min_unit_assert.svh
// Assertion macros shared by the range reservation unit.
// ============================================================================
`ifndef RANGE_RESERVE_ADD_ASSIGN_MIN_UNIT_ASSERT_SVH
`define RANGE_RESERVE_ADD_ASSIGN_MIN_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rrm: property violated");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RRM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("rrm: property violated");

`endif

// ===== hdl/rrm_pkg.sv =====
// ============================================================================
// rrm_pkg
// Types and constants of the range reservation unit.
// ============================================================================
package rrm_pkg;

    localparam int ENTRIES    = 1024;
    localparam int LEVEL_BITS = 32;
    localparam int CELLS      = 32;
    localparam int CELL_DEPTH = ENTRIES / CELLS;
    localparam int ADDR_W     = $clog2(CELL_DEPTH);
    localparam int CELL_W     = $clog2(CELLS);
    localparam int IDX_W      = CELL_W + ADDR_W;
    localparam int CNT_W      = ((ADDR_W > CELL_W) ? ADDR_W : CELL_W) + 1;
    localparam int IN_IDX_W   = 11;
    localparam int AMT_W      = 31;
    localparam int CNT_OUT_W  = 32;

    // Request commands
    localparam logic [1:0] CMD_RESERVE = 2'd0;
    localparam logic [1:0] CMD_ADD     = 2'd1;
    localparam logic [1:0] CMD_ASSIGN  = 2'd2;

    // Register indexes
    localparam logic REG_ACTIVE = 1'b0;
    localparam logic REG_INIT   = 1'b1;

    typedef struct packed {
        logic [1:0]          command;
        logic [IN_IDX_W-1:0] first_index;
        logic [IN_IDX_W-1:0] last_index;
        logic [AMT_W-1:0]    amount;
    } t_req;

    typedef struct packed {
        logic                 granted;
        logic [CNT_OUT_W-1:0] grant_count;
    } t_rsp;

    typedef enum logic [2:0] {
        MODE_HOLD,
        MODE_CLEAR,
        MODE_CHECK,
        MODE_ADD,
        MODE_SUB,
        MODE_SET
    } t_mode;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        t_mode                 mode;
        logic [LEVEL_BITS-1:0] value;
        logic [IDX_W-1:0]      lo0;
        logic [IDX_W-1:0]      hi0;
        logic                  clr_bad;
    } t_cell_ctl;

endpackage

// ===== hdl/rrm_cell.sv =====
// ============================================================================
// rrm_cell
// One cell of the chain: a slice of the level array with read-modify-write.
// ============================================================================
module rrm_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rrm_pkg::CELL_W-1:0]    i_cell_idx,
    input  rrm_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_ok,
    output logic                          o_ok
);

    logic [rrm_pkg::LEVEL_BITS-1:0] mem [rrm_pkg::CELL_DEPTH];

    logic [rrm_pkg::LEVEL_BITS-1:0] r_rd;
    logic [rrm_pkg::ADDR_W-1:0]     r_addr;
    logic                           r_pend;
    logic                           r_bad;
    logic                           r_ok;

    logic [rrm_pkg::IDX_W-1:0]      gidx;
    logic                           in_rng;
    logic                           wr_en;
    logic [rrm_pkg::LEVEL_BITS-1:0] wr_data;
    logic                           bad_hit;

    assign gidx   = {i_cell_idx, r_addr};
    assign in_rng = (gidx >= i_ctl.lo0) && (gidx <= i_ctl.hi0);

    always_comb begin
        wr_en   = 1'b0;
        wr_data = i_ctl.value;
        case (i_ctl.mode)
            rrm_pkg::MODE_CLEAR: wr_en = r_pend;
            rrm_pkg::MODE_ADD: begin
                wr_en   = r_pend && in_rng;
                wr_data = r_rd + i_ctl.value;
            end
            rrm_pkg::MODE_SUB: begin
                wr_en   = r_pend && in_rng;
                wr_data = r_rd - i_ctl.value;
            end
            rrm_pkg::MODE_SET: wr_en = r_pend && in_rng;
            default:           wr_en = 1'b0;
        endcase
    end

    // level counts as positive when nonzero and sign clear
    assign bad_hit = r_pend && (i_ctl.mode == rrm_pkg::MODE_CHECK) && in_rng
                     && ((r_rd == '0) || r_rd[rrm_pkg::LEVEL_BITS-1]);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd <= mem[i_ctl.rd_addr];
        end
        r_addr <= i_ctl.rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_bad  <= 1'b0;
            r_ok   <= 1'b0;
        end else begin
            r_pend <= i_ctl.rd_en;
            if (i_ctl.clr_bad) begin
                r_bad <= 1'b0;
            end else if (bad_hit) begin
                r_bad <= 1'b1;
            end
            // hand the running verdict to the next cell
            r_ok <= i_ok && !r_bad;
        end
    end

    assign o_ok = r_ok;

endmodule

// ===== hdl/range_reserve_add_assign_min_unit.sv =====
// ============================================================================
// range_reserve_add_assign_min_unit
// Range reservation over an array of signed capacity levels, kept in a chain
// of cells that each own a slice of the array.
// ============================================================================
//
// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  ------------------------------
// in        in         i_in_valid / o_in_ready  i_in_req  (command, range, amt)
// out       out        o_out_valid / i_out_ready o_out_rsp (granted, count)
// cfg       in         psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// The levels live in CELLS cells of CELL_DEPTH entries each (32 x 32).
// All cells sweep their slice in step, one entry a cycle through their memory
// port. An add or assign request makes one sweep that updates the range. A
// reserve request first sweeps to check the range, then ripples the verdict
// through the chain one cell a cycle, and if granted sweeps again to subtract;
// if refused it goes straight to the response. An empty or reversed range, or
// an unknown command, also goes straight to the response. Reset and every
// register write run a clearing pass that loads the initial level; no request
// is taken meanwhile.
// A request is taken while the previous response waits in the output
// register; a stalled response holds the sequencer only at its end.
//
module range_reserve_add_assign_min_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // request channel
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rrm_pkg::t_req  i_in_req,
    // response channel
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rrm_pkg::t_rsp  o_out_rsp,
    // configuration port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

`include "range_reserve_add_assign_min_unit_assert.svh"

    localparam logic [rrm_pkg::CNT_W-1:0] CNT_DEPTH = rrm_pkg::CNT_W'(rrm_pkg::CELL_DEPTH);
    localparam logic [rrm_pkg::CNT_W-1:0] CNT_CELLS = rrm_pkg::CNT_W'(rrm_pkg::CELLS);
    localparam logic [rrm_pkg::IN_IDX_W-1:0] IDX_ONE = rrm_pkg::IN_IDX_W'(1);
    localparam logic [rrm_pkg::IN_IDX_W-1:0] IDX_MAX = rrm_pkg::IN_IDX_W'(rrm_pkg::ENTRIES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_CHAIN,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [rrm_pkg::CNT_W-1:0]       r_cnt;
    logic [rrm_pkg::IN_IDX_W-1:0]    r_active;
    logic [rrm_pkg::AMT_W-1:0]       r_init;
    logic [rrm_pkg::CNT_OUT_W-1:0]   r_gcnt;
    logic [1:0]                      r_cmd;
    logic [rrm_pkg::AMT_W-1:0]       r_amt;
    logic [rrm_pkg::IDX_W-1:0]       r_lo0;
    logic [rrm_pkg::IDX_W-1:0]       r_hi0;
    logic                            r_granted;
    logic                            r_out_valid;
    rrm_pkg::t_rsp                   r_out_rsp;

    logic                            cfg_wr;
    logic                            in_acc;
    logic [rrm_pkg::IN_IDX_W-1:0]    n_use;
    logic [rrm_pkg::IN_IDX_W-1:0]    lo;
    logic [rrm_pkg::IN_IDX_W-1:0]    hi;
    logic [rrm_pkg::IN_IDX_W-1:0]    lo_m1;
    logic [rrm_pkg::IN_IDX_W-1:0]    hi_m1;
    logic                            nonempty;
    t_state                          n_dispatch;
    rrm_pkg::t_cell_ctl              ctl;
    logic [rrm_pkg::CELLS:0]         ok_chain;
    logic                            chain_ok;
    logic                            chain_end;
    logic                            rsp_load;

    // ------------------------------------------------------------------
    // Configuration port: always ready, write on the access phase
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            rrm_pkg::REG_ACTIVE: prdata = {21'd0, r_active};
            rrm_pkg::REG_INIT:   prdata = {1'b0, r_init};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Range clipping: active count 0 acts as 1, above ENTRIES as ENTRIES
    // ------------------------------------------------------------------
    always_comb begin
        if (r_active == '0) begin
            n_use = IDX_ONE;
        end else if (r_active > IDX_MAX) begin
            n_use = IDX_MAX;
        end else begin
            n_use = r_active;
        end
        lo       = (i_in_req.first_index == '0) ? IDX_ONE : i_in_req.first_index;
        hi       = (i_in_req.last_index > n_use) ? n_use : i_in_req.last_index;
        nonempty = (lo <= hi);
        lo_m1    = lo - IDX_ONE;
        hi_m1    = hi - IDX_ONE;
    end

    // pick the first phase of an accepted request
    always_comb begin
        case (i_in_req.command) inside
            rrm_pkg::CMD_RESERVE:                   n_dispatch = nonempty ? S_CHECK : S_DONE;
            rrm_pkg::CMD_ADD, rrm_pkg::CMD_ASSIGN: n_dispatch = nonempty ? S_UPDATE : S_DONE;
            default:                                n_dispatch = S_DONE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Broadcast to the cells
    // ------------------------------------------------------------------
    always_comb begin
        ctl.rd_addr = r_cnt[rrm_pkg::ADDR_W-1:0];
        ctl.lo0     = r_lo0;
        ctl.hi0     = r_hi0;
        ctl.clr_bad = (r_state == S_IDLE);
        ctl.value   = rrm_pkg::LEVEL_BITS'(r_amt);
        ctl.rd_en   = 1'b0;
        ctl.mode    = rrm_pkg::MODE_HOLD;
        unique case (r_state)
            S_CLEAR: begin
                ctl.rd_en = (r_cnt < CNT_DEPTH);
                ctl.mode  = rrm_pkg::MODE_CLEAR;
                ctl.value = rrm_pkg::LEVEL_BITS'(r_init);
            end
            S_CHECK: begin
                ctl.rd_en = (r_cnt < CNT_DEPTH);
                ctl.mode  = rrm_pkg::MODE_CHECK;
            end
            S_UPDATE: begin
                ctl.rd_en = (r_cnt < CNT_DEPTH);
                case (r_cmd)
                    rrm_pkg::CMD_RESERVE: ctl.mode = rrm_pkg::MODE_SUB;
                    rrm_pkg::CMD_ADD:     ctl.mode = rrm_pkg::MODE_ADD;
                    rrm_pkg::CMD_ASSIGN:  ctl.mode = rrm_pkg::MODE_SET;
                    default:              ctl.mode = rrm_pkg::MODE_HOLD;
                endcase
            end
            default: ctl.mode = rrm_pkg::MODE_HOLD;
        endcase
    end

    // ------------------------------------------------------------------
    // Chain of cells; the check verdict ripples from cell 0 upward
    // ------------------------------------------------------------------
    assign ok_chain[0] = 1'b1;

    for (genvar k = 0; k < rrm_pkg::CELLS; k++) begin : g_cell
        rrm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (rrm_pkg::CELL_W'(k)),
            .i_ctl      (ctl),
            .i_ok       (ok_chain[k]),
            .o_ok       (ok_chain[k+1])
        );
    end

    assign chain_ok  = ok_chain[rrm_pkg::CELLS];
    assign chain_end = (r_state == S_CHAIN) && (r_cnt == CNT_CELLS) && !cfg_wr;

    // load the output register when a finished request finds it free
    assign rsp_load = (r_state == S_DONE) && !cfg_wr && (!r_out_valid || i_out_ready);

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_active    <= IDX_MAX;
            r_init      <= '0;
            r_gcnt      <= '0;
            r_granted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // load the response, or drop it once taken
            if (rsp_load) begin
                r_out_valid           <= 1'b1;
                r_out_rsp.granted     <= r_granted;
                r_out_rsp.grant_count <= r_gcnt;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                // any register write restarts the block
                unique case (paddr[2])
                    rrm_pkg::REG_ACTIVE: r_active <= pwdata[rrm_pkg::IN_IDX_W-1:0];
                    rrm_pkg::REG_INIT:   r_init   <= pwdata[rrm_pkg::AMT_W-1:0];
                endcase
                r_state <= S_CLEAR;
                r_cnt   <= '0;
                r_gcnt  <= '0;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        if (r_cnt == CNT_DEPTH) begin
                            r_state <= S_IDLE;
                            r_cnt   <= '0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    S_IDLE: begin
                        if (in_acc) begin
                            r_cmd     <= i_in_req.command;
                            r_amt     <= i_in_req.amount;
                            r_lo0     <= lo_m1[rrm_pkg::IDX_W-1:0];
                            r_hi0     <= hi_m1[rrm_pkg::IDX_W-1:0];
                            r_granted <= 1'b0;
                            r_cnt     <= '0;
                            r_state   <= n_dispatch;
                        end
                    end
                    S_CHECK: begin
                        if (r_cnt == CNT_DEPTH) begin
                            r_cnt   <= '0;
                            r_state <= S_CHAIN;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    S_CHAIN: begin
                        // the verdict has rippled to the last cell when r_cnt reaches CELLS
                        if (r_cnt == CNT_CELLS) begin
                            r_cnt <= '0;
                            if (chain_ok) begin
                                r_gcnt    <= r_gcnt + 1'b1;
                                r_granted <= 1'b1;
                                r_state   <= S_UPDATE;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    S_UPDATE: begin
                        if (r_cnt == CNT_DEPTH) begin
                            r_cnt   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    S_DONE: begin
                        // hold until the output register is free
                        if (rsp_load) begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RRM_ASSERT_NXT(a_refused_done, chain_end && !chain_ok, r_state == S_DONE)
    `RRM_ASSERT_NXT(a_refused_keeps, chain_end && !chain_ok, r_gcnt == $past(r_gcnt))
    `RRM_ASSERT_NXT(a_grant_bumps, chain_end && chain_ok, r_gcnt == $past(r_gcnt) + 1'b1)
    `RRM_ASSERT_NXT(a_cfg_restarts, cfg_wr, r_state == S_CLEAR && r_cnt == '0 && r_gcnt == '0)
    `RRM_ASSERT_NXT(a_accept_leaves_idle, in_acc, (!o_in_ready))

endmodule
